[hw/rtl/mlpfs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package mlpfs_pkg;

  localparam int MaxHidden   = 4;
  localparam int MaxWidth    = 16;
  localparam int Slots       = MaxWidth + 1;
  localparam int StoreDepth  = (MaxHidden + 1) * MaxWidth * Slots;
  localparam int AddrW       = $clog2(StoreDepth);
  localparam int NeuronW     = $clog2(MaxWidth);
  localparam int SlotW       = $clog2(Slots);
  localparam int AccW        = 40;

  localparam logic [1:0] RegNumInputs  = 2'd0;
  localparam logic [1:0] RegNumHidden  = 2'd1;
  localparam logic [1:0] RegHiddenSize = 2'd2;
  localparam logic [1:0] RegNumOutputs = 2'd3;

  typedef struct packed {
    logic [15:0] weight_value;
    logic [4:0]  weight_slot;
    logic [3:0]  weight_neuron;
    logic [2:0]  weight_layer;
    logic        kind;
    logic [15:0] sample_value;
    logic        sample_last;
  } in_item_t;

  typedef struct packed {
    logic [12:0] output_value;
    logic [3:0]  output_index;
    logic        count_error;
    logic        last;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic               acc_clear;   // start neuron: acc loads the first product
    logic               acc_bias;    // current product is the bias term
    logic               acc_add;     // accumulate current product
    logic [AddrW-1:0]   w_addr;
    logic [SlotW-1:0]   k;           // activation read index
    logic               src_b;       // source buffer is act_b
    logic               act_write;   // write sigmoid result
    logic [NeuronW-1:0] j;
    logic               out_rd;      // read final buffer at index j
  } ctrl_t;

  typedef struct packed {
    logic [12:0] out_value;
  } stat_t;

  function automatic logic [12:0] sig_tab(input logic [6:0] i);
    logic [12:0] t;
    case (i)
      7'd0: t = 13'd1;     7'd1: t = 13'd2;     7'd2: t = 13'd2;     7'd3: t = 13'd3;
      7'd4: t = 13'd4;     7'd5: t = 13'd5;     7'd6: t = 13'd6;     7'd7: t = 13'd8;
      7'd8: t = 13'd10;    7'd9: t = 13'd13;    7'd10: t = 13'd17;   7'd11: t = 13'd21;
      7'd12: t = 13'd27;   7'd13: t = 13'd35;   7'd14: t = 13'd45;   7'd15: t = 13'd58;
      7'd16: t = 13'd74;   7'd17: t = 13'd94;   7'd18: t = 13'd120;  7'd19: t = 13'd153;
      7'd20: t = 13'd194;  7'd21: t = 13'd246;  7'd22: t = 13'd311;  7'd23: t = 13'd391;
      7'd24: t = 13'd488;  7'd25: t = 13'd606;  7'd26: t = 13'd747;  7'd27: t = 13'd912;
      7'd28: t = 13'd1102; 7'd29: t = 13'd1314; 7'd30: t = 13'd1546; 7'd31: t = 13'd1793;
      7'd32: t = 13'd2048; 7'd33: t = 13'd2303; 7'd34: t = 13'd2550; 7'd35: t = 13'd2782;
      7'd36: t = 13'd2994; 7'd37: t = 13'd3184; 7'd38: t = 13'd3349; 7'd39: t = 13'd3490;
      7'd40: t = 13'd3608; 7'd41: t = 13'd3705; 7'd42: t = 13'd3785; 7'd43: t = 13'd3850;
      7'd44: t = 13'd3902; 7'd45: t = 13'd3943; 7'd46: t = 13'd3976; 7'd47: t = 13'd4002;
      7'd48: t = 13'd4022; 7'd49: t = 13'd4038; 7'd50: t = 13'd4051; 7'd51: t = 13'd4061;
      7'd52: t = 13'd4069; 7'd53: t = 13'd4075; 7'd54: t = 13'd4079; 7'd55: t = 13'd4083;
      7'd56: t = 13'd4086; 7'd57: t = 13'd4088; 7'd58: t = 13'd4090; 7'd59: t = 13'd4091;
      7'd60: t = 13'd4092; 7'd61: t = 13'd4093; 7'd62: t = 13'd4094; 7'd63: t = 13'd4094;
      7'd64: t = 13'd4095;
      default: t = 13'd4095;
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/mlpfs_stream_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface mlpfs_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[hw/rtl/mlp_forward_sigmoid_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// weight loads and non-final sample elements are accepted only while idle with no result waiting
// final element runs the pass on one mac unit: per neuron, its inputs and bias, a drain, a write-back
// then each output result is read from the final buffer and presented in turn
// a count error gives a single result in the cycle after the item
// synchronous active-high reset restores register defaults and clears the element count
module mlp_forward_sigmoid_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  mlpfs_stream_if.sink     in_ch,
  mlpfs_stream_if.source   out_ch
);

  mlpfs_pkg::ctrl_t ctrl;
  mlpfs_pkg::stat_t stat;
  logic w_we, s_we, from_dp, err, lst;
  logic [mlpfs_pkg::AddrW-1:0] w_waddr;
  logic [mlpfs_pkg::NeuronW-1:0] s_waddr;
  logic [3:0] idx;

  mlpfs_ctrl u_ctrl (
    .clk, .rst, .cfg_we, .cfg_idx(cfg_index), .cfg_data,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_item(in_ch.data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_index(idx), .out_err(err), .out_last(lst), .out_from_dp(from_dp),
    .w_we, .w_waddr, .s_we, .s_waddr, .ctrl
  );

  mlpfs_datapath u_dp (
    .clk, .ctrl, .w_we, .w_waddr, .w_wdata(in_ch.data.weight_value),
    .s_we, .s_waddr, .s_wdata(in_ch.data.sample_value), .stat
  );

  always_comb begin
    out_ch.data.output_value = from_dp ? stat.out_value : 13'd0;
    out_ch.data.output_index = idx;
    out_ch.data.count_error = err;
    out_ch.data.last = lst;
  end

endmodule
`default_nettype wire

[hw/rtl/mlpfs_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
module mlpfs_datapath (
  input  wire logic                       clk,
  input  wire mlpfs_pkg::ctrl_t           ctrl,
  input  wire logic                       w_we,
  input  wire logic [mlpfs_pkg::AddrW-1:0] w_waddr,
  input  wire logic [15:0]                w_wdata,
  input  wire logic                       s_we,
  input  wire logic [mlpfs_pkg::NeuronW-1:0] s_waddr,
  input  wire logic [15:0]                s_wdata,
  output mlpfs_pkg::stat_t                stat
);

  logic [15:0] wmem [mlpfs_pkg::StoreDepth];
  logic [15:0] act_a [mlpfs_pkg::MaxWidth];
  logic [15:0] act_b [mlpfs_pkg::MaxWidth];

  logic signed [15:0] w_q, x_q;
  logic               bias_q, clear_q, add_q;
  logic signed [31:0] prod;
  logic               bias_p, clear_p, add_p;
  logic signed [mlpfs_pkg::AccW-1:0] acc;
  logic [12:0]        out_value;

  logic signed [mlpfs_pkg::AccW-1:0] rnd;
  logic signed [mlpfs_pkg::AccW-13:0] zw;
  logic [15:0] p;
  logic [12:0] t0, t1, sig_out;
  logic signed [13:0] d;
  logic signed [25:0] dm;

  logic [mlpfs_pkg::NeuronW-1:0] kk;
  assign kk = ctrl.k[mlpfs_pkg::NeuronW-1:0];

  // weight memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (w_we) wmem[w_waddr] <= w_wdata;
    w_q <= wmem[ctrl.w_addr];
  end

  always_ff @(posedge clk) begin
    if (s_we) act_a[s_waddr] <= s_wdata;
    else if (ctrl.act_write && ctrl.src_b) act_a[ctrl.j] <= {3'd0, sig_out};
    if (ctrl.act_write && !ctrl.src_b) act_b[ctrl.j] <= {3'd0, sig_out};
    x_q     <= ctrl.src_b ? act_b[kk] : act_a[kk];
    bias_q  <= ctrl.acc_bias;
    clear_q <= ctrl.acc_clear;
    add_q   <= ctrl.acc_add;
    if (ctrl.out_rd) out_value <= ctrl.src_b ? act_b[ctrl.j][12:0] : act_a[ctrl.j][12:0];
  end

  // multiply stage
  always_ff @(posedge clk) begin
    prod    <= bias_q ? (32'(w_q) <<< 12) : w_q * x_q;
    bias_p  <= bias_q;
    clear_p <= clear_q;
    add_p   <= add_q;
  end

  // first product of a neuron restarts the sum
  always_ff @(posedge clk) begin
    if (clear_p) acc <= mlpfs_pkg::AccW'(prod);
    else if (add_p || bias_p) acc <= acc + mlpfs_pkg::AccW'(prod);
  end

  // round, saturate, sigmoid
  always_comb begin
    rnd = acc + mlpfs_pkg::AccW'(2048);
    zw  = rnd[mlpfs_pkg::AccW-1:12];
    if (zw < -32768) p = 16'd0;
    else if (zw > 32767) p = 16'hffff;
    else p = zw[15:0] ^ 16'h8000;
    t0 = mlpfs_pkg::sig_tab({1'b0, p[15:10]});
    t1 = mlpfs_pkg::sig_tab(7'({1'b0, p[15:10]} + 7'd1));
    d  = 14'(t1) - 14'(t0);
    dm = 26'(d) * $signed({16'd0, p[9:0]}) + 26'sd512;
    sig_out = t0 + 13'(dm >>> 10);
  end

  assign stat.out_value = out_value;

endmodule
`default_nettype wire

[hw/rtl/mlpfs_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module mlpfs_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_we,
  input  wire logic [1:0]      cfg_idx,
  input  wire logic [15:0]     cfg_data,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire mlpfs_pkg::in_item_t in_item,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [3:0]           out_index,
  output logic                 out_err,
  output logic                 out_last,
  output logic                 out_from_dp,
  output logic                 w_we,
  output logic [mlpfs_pkg::AddrW-1:0] w_waddr,
  output logic                 s_we,
  output logic [mlpfs_pkg::NeuronW-1:0] s_waddr,
  output mlpfs_pkg::ctrl_t     ctrl
);

  typedef enum logic [2:0] {IDLE, MAC, DRAIN, NEXT, ORD, OUT} state_t;
  state_t state;

  logic [4:0]  num_inputs, num_outputs;
  logic [2:0]  num_hidden;
  logic [15:0] hidden_sizes;
  logic [4:0]  elem_cnt;
  logic [2:0]  layer;
  logic [4:0]  n, m, j, k;
  logic [2:0]  drain;
  logic        src_b;

  logic [4:0] n_in, n_out;
  logic [2:0] n_hid;
  logic [4:0] m_cur;
  always_comb begin
    n_in  = (num_inputs == 5'd0) ? 5'd1 : (num_inputs > 5'd16 ? 5'd16 : num_inputs);
    n_out = (num_outputs == 5'd0) ? 5'd1 : (num_outputs > 5'd16 ? 5'd16 : num_outputs);
    n_hid = (num_hidden == 3'd0) ? 3'd1 : (num_hidden > 3'd4 ? 3'd4 : num_hidden);
    if (layer < n_hid) m_cur = 5'(hidden_sizes[4*layer[1:0] +: 4]) + 5'd1;
    else m_cur = n_out;
  end

  logic acc_in;
  assign acc_in = in_valid && in_ready;
  assign in_ready = (state == IDLE) && !out_valid;

  // weight and sample writes
  always_comb begin
    w_we = acc_in && !in_item.kind && in_item.weight_layer <= 3'd4
           && in_item.weight_slot <= 5'd16;
    w_waddr = mlpfs_pkg::AddrW'((32'(in_item.weight_layer) * 16 + 32'(in_item.weight_neuron))
              * 17 + 32'(in_item.weight_slot));
    s_we = acc_in && in_item.kind && elem_cnt < n_in;
    s_waddr = elem_cnt[3:0];
  end

  // datapath control; the final buffer is read only when no item waits or the waiting one is taken
  always_comb begin
    ctrl = '0;
    ctrl.src_b = src_b;
    ctrl.j = j[3:0];
    ctrl.k = k;
    ctrl.w_addr = mlpfs_pkg::AddrW'((32'(layer) * 16 + 32'(j)) * 17 + 32'(k));
    ctrl.acc_clear = (state == MAC) && (k == 5'd0);
    ctrl.acc_bias = (state == MAC) && (k == n);
    ctrl.acc_add = (state == MAC) && (k < n);
    ctrl.act_write = (state == NEXT);
    ctrl.out_rd = (state == ORD) && (!out_valid || out_ready);
  end

  // one neuron: n+1 reads, a drain while the pipeline settles, one write
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE; num_inputs <= 5'd16; num_hidden <= 3'd1;
      hidden_sizes <= 16'hffff; num_outputs <= 5'd1; elem_cnt <= '0;
      out_valid <= 1'b0; out_from_dp <= 1'b0; src_b <= 1'b0;
      layer <= '0; n <= '0; m <= '0; j <= '0; k <= '0; drain <= '0;
      out_index <= '0; out_err <= 1'b0; out_last <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          mlpfs_pkg::RegNumInputs:  num_inputs <= cfg_data[4:0];
          mlpfs_pkg::RegNumHidden:  num_hidden <= cfg_data[2:0];
          mlpfs_pkg::RegHiddenSize: hidden_sizes <= cfg_data;
          mlpfs_pkg::RegNumOutputs: num_outputs <= cfg_data[4:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        IDLE: if (acc_in && in_item.kind) begin
          if (in_item.sample_last) begin
            elem_cnt <= '0;
            if (((elem_cnt == 5'd31) ? 5'd31 : elem_cnt + 5'd1) != n_in) begin
              out_valid <= 1'b1; out_from_dp <= 1'b0; out_err <= 1'b1;
              out_last <= 1'b1; out_index <= '0;
            end else begin
              state <= MAC; layer <= '0; n <= n_in; j <= '0; k <= '0; src_b <= 1'b0;
            end
          end else if (elem_cnt != 5'd31) elem_cnt <= elem_cnt + 5'd1;
        end
        MAC: begin
          m <= m_cur;
          if (k == n) begin state <= DRAIN; drain <= 3'd3; end
          else k <= k + 5'd1;
        end
        DRAIN: begin
          if (drain == 3'd1) state <= NEXT;
          drain <= drain - 3'd1;
        end
        NEXT: begin
          k <= '0;
          if (j + 5'd1 < m) begin j <= j + 5'd1; state <= MAC; end
          else begin
            j <= '0; src_b <= !src_b;
            if (layer == n_hid) state <= ORD;
            else begin layer <= layer + 3'd1; n <= m; state <= MAC; end
          end
        end
        ORD: if (!out_valid || out_ready) begin
          state <= OUT;
        end
        OUT: begin
          out_valid <= 1'b1; out_from_dp <= 1'b1; out_err <= 1'b0;
          out_index <= j[3:0]; out_last <= (j + 5'd1 == m);
          if (j + 5'd1 == m) state <= IDLE;
          else begin j <= j + 5'd1; state <= ORD; end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
